// File: src/mts_pkg.sv
package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;

    localparam count_t FULL_COUNT = COUNT_BITS'(STACK_DEPTH);

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Operation codes.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic fill;
    } mts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic need_fill;
    } mts_stat_t;

endpackage

// File: src/mts_ctrl.sv
module mts_ctrl
    import mts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mts_stat_t stat,
    output mts_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FILL = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept && stat.need_fill)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/mts_datapath.sv
module mts_datapath
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode,
    input  word_t      value,
    input  mts_cmd_t   cmd,
    output mts_stat_t  stat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output word_t      top_value,
    output word_t      max_value,
    output count_t     entry_count
);

    word_t  value_mem [STACK_DEPTH];
    word_t  max_mem   [STACK_DEPTH];

    count_t count_reg,  count_next;
    count_t mcount_reg, mcount_next;
    word_t  top_reg,    top_next;
    word_t  max_reg,    max_next;
    logic   max_refill_reg, max_refill_next;
    word_t  v_rd_reg;
    word_t  m_rd_reg;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg;
    word_t      out_top_reg;
    word_t      out_max_reg;
    count_t     out_count_reg;

    logic       out_load;
    logic [1:0] load_status;
    logic       v_we, m_we, rd_en;

    count_t cnt_dec, cnt_dec2, mcnt_dec, mcnt_dec2;
    logic   is_push, full, empty, push_max, pop_max;

    assign cnt_dec   = count_reg - COUNT_BITS'(1);
    assign cnt_dec2  = count_reg - COUNT_BITS'(2);
    assign mcnt_dec  = mcount_reg - COUNT_BITS'(1);
    assign mcnt_dec2 = mcount_reg - COUNT_BITS'(2);

    assign is_push  = (mode == MODE_PUSH);
    assign full     = (count_reg == FULL_COUNT);
    assign empty    = (count_reg == '0);
    assign push_max = (mcount_reg != FULL_COUNT)
                      && (empty || (mcount_reg == '0) || (value >= max_reg));
    assign pop_max  = (mcount_reg != '0) && (top_reg == max_reg);

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.need_fill = !is_push && !empty && (cnt_dec != '0);

    always_comb
    begin
        count_next      = count_reg;
        mcount_next     = mcount_reg;
        top_next        = top_reg;
        max_next        = max_reg;
        max_refill_next = max_refill_reg;
        v_we            = 1'b0;
        m_we            = 1'b0;
        rd_en           = 1'b0;
        out_load        = 1'b0;
        load_status     = ST_OK;

        if (cmd.accept)
        begin
            if (is_push)
            begin
                out_load = 1'b1;
                if (full)
                begin
                    load_status = ST_FULL;
                end
                else
                begin
                    v_we       = 1'b1;
                    top_next   = value;
                    count_next = count_reg + COUNT_BITS'(1);
                    if (push_max)
                    begin
                        m_we        = 1'b1;
                        max_next    = value;
                        mcount_next = mcount_reg + COUNT_BITS'(1);
                    end
                end
            end
            else if (empty)
            begin
                out_load    = 1'b1;
                load_status = ST_EMPTY;
            end
            else
            begin
                count_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    // Last entry gone: both stacks are cleared.
                    mcount_next = '0;
                    top_next    = '0;
                    max_next    = '0;
                    out_load    = 1'b1;
                end
                else
                begin
                    // The caches are refilled from the stores next cycle.
                    rd_en = 1'b1;
                    if (pop_max)
                    begin
                        mcount_next     = mcnt_dec;
                        max_refill_next = (mcnt_dec != '0);
                        if (mcnt_dec == '0)
                        begin
                            max_next = '0;
                        end
                    end
                    else
                    begin
                        max_refill_next = 1'b0;
                    end
                end
            end
        end

        if (cmd.fill)
        begin
            top_next = v_rd_reg;
            if (max_refill_reg)
            begin
                max_next = m_rd_reg;
            end
            out_load = 1'b1;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            value_mem[count_reg[ADDR_BITS-1:0]] <= value;
        end
        if (rd_en)
        begin
            v_rd_reg <= value_mem[cnt_dec2[ADDR_BITS-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            max_mem[mcount_reg[ADDR_BITS-1:0]] <= value;
        end
        if (rd_en)
        begin
            m_rd_reg <= max_mem[mcnt_dec2[ADDR_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            mcount_reg     <= '0;
            top_reg        <= '0;
            max_reg        <= '0;
            max_refill_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            mcount_reg     <= mcount_next;
            top_reg        <= top_next;
            max_reg        <= max_next;
            max_refill_reg <= max_refill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= load_status;
            out_top_reg    <= top_next;
            out_max_reg    <= max_next;
            out_count_reg  <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign top_value   = out_top_reg;
    assign max_value   = out_max_reg;
    assign entry_count = out_count_reg;

endmodule

// File: src/max_tracking_stack.sv
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------
// in      | in_valid / in_ready  | mode, value
// out     | out_valid / out_ready| status, top_value, max_value, entry_count
//
// A push, a failed operation or a pop that empties the stack loads its
// result directly. A pop that leaves entries first does a registered read
// of the value and maximum stores that refills the cached top and maximum.
// Reset clears the counts and the caches; the stores need no clearing pass.
// The result waits in an output register; outside a refill, a new item is
// taken as the previous result is taken, or whenever the register is empty.

module max_tracking_stack
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  word_t      value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output word_t      top_value,
    output word_t      max_value,
    output count_t     entry_count
);

    // The controller only sequences; all state of the stack sits in the
    // datapath, which also owns the two stores.
    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mts_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .top_value   (top_value),
        .max_value   (max_value),
        .entry_count (entry_count)
    );

endmodule

// File: src/mts_checker.sv
module mts_checker
    import mts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input word_t      top_value,
    input word_t      max_value,
    input count_t     entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(top_value) && $stable(max_value) && $stable(entry_count))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_count == '0) |-> (top_value == '0) && (max_value == '0))
        else $error("empty stack shows a non-zero top or maximum");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (entry_count == FULL_COUNT))
        else $error("full error with a stack that is not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (entry_count == '0))
        else $error("empty error with a stack that holds entries");

    a_max_ge_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_count != '0) |-> (max_value >= top_value))
        else $error("maximum below the top entry");

endmodule

bind max_tracking_stack mts_checker u_mts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .top_value   (top_value),
    .max_value   (max_value),
    .entry_count (entry_count)
);
